/* design/swe_pkg.sv */
package swe_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int WSIZE_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAKE_MIN    = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Running extreme travelling down the cell chain
  typedef struct packed {
    logic    valid;
    sample_t best;
  } swe_tok_t;

endpackage

/* design/sliding_window_extreme_top.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------
// input    | in_valid / in_ready  | sample (s32), restart (1)
// output   | out_valid / out_ready| window_extreme (s32)
// config   | cfg_write            | cfg_index (0 window_size, 1 take_min), cfg_data
//
// An item that gives no result leaves input ready. An item that gives a result
// holds in_ready low until the running extreme has walked the whole cell chain,
// one cell per cycle while the chain is not held, and landed in the output register.
// Reset (synchronous, rst high) empties the window and sets window_size 1, maximum.
// A result waiting in the output register stalls the chain only when the next
// result reaches the chain end; a pending result alone does not block input.
module sliding_window_extreme_top #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [swe_pkg::SAMPLE_W-1:0] sample,
  input  logic                             restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [swe_pkg::SAMPLE_W-1:0] window_extreme,
  input  logic                             cfg_write,
  input  logic [swe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swe_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (CNT_W > swe_pkg::WSIZE_W) ? CNT_W : swe_pkg::WSIZE_W;

  logic [swe_pkg::WSIZE_W-1:0] window_size;
  logic                        take_min;
  logic [CNT_W-1:0]            fill;
  logic [CNT_W-1:0]            fill_next;
  logic [CMP_W-1:0]            w_clamp;
  logic                        emit;
  logic                        busy;
  logic                        start;
  logic                        accept;
  logic                        adv;
  logic                        load;

  swe_pkg::sample_t    samp [WINDOW_MAX+1];
  swe_pkg::swe_tok_t   tok  [WINDOW_MAX+1];
  logic [WINDOW_MAX-1:0] in_window;
  swe_pkg::sample_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swe_pkg::WSIZE_W'(1);
      take_min    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        swe_pkg::REG_WINDOW_SIZE: window_size <= cfg_data[swe_pkg::WSIZE_W-1:0];
        swe_pkg::REG_TAKE_MIN:    take_min    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (CMP_W'(window_size) > CMP_W'(WINDOW_MAX)) begin
      w_clamp = CMP_W'(WINDOW_MAX);
    end else begin
      w_clamp = CMP_W'(window_size);
    end
  end

  always_comb begin
    if (restart) begin
      fill_next = CNT_W'(1);
    end else if (fill == CNT_W'(WINDOW_MAX)) begin
      fill_next = fill;
    end else begin
      fill_next = fill + CNT_W'(1);
    end
  end

  assign emit     = (w_clamp != '0) && (CMP_W'(fill_next) >= w_clamp);
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign load     = tok[WINDOW_MAX].valid && (!out_valid || out_ready);
  // Hold the chain while a finished result cannot enter the output register
  assign adv      = !(tok[WINDOW_MAX].valid && out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      busy  <= 1'b0;
      start <= 1'b0;
    end else begin
      if (accept) begin
        fill <= fill_next;
      end
      if (accept) begin
        start <= emit;
      end else if (adv) begin
        start <= 1'b0;
      end
      if (accept && emit) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
    end
  end

  assign samp[0]       = sample;
  assign tok[0].valid  = start;
  assign tok[0].best   = samp[1];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    assign in_window[i] = (CMP_W'(i) < w_clamp);

    swe_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (accept),
      .adv        (adv),
      .in_window  (in_window[i]),
      .take_min   (take_min),
      .sample_in  (samp[i]),
      .sample_out (samp[i+1]),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= tok[WINDOW_MAX].best;
    end
  end

  assign window_extreme = result;

endmodule

/* design/swe_cell.sv */
module swe_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  logic             adv,
  input  logic             in_window,
  input  logic             take_min,
  input  swe_pkg::sample_t sample_in,
  output swe_pkg::sample_t sample_out,
  input  swe_pkg::swe_tok_t tok_in,
  output swe_pkg::swe_tok_t tok_out
);

  swe_pkg::sample_t held;
  swe_pkg::sample_t pick;
  logic             tok_valid;
  swe_pkg::sample_t tok_best;

  // Sample line: advance by one place per accepted item
  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= sample_in;
    end
  end

  always_comb begin
    if (take_min) begin
      pick = (held < tok_in.best) ? held : tok_in.best;
    end else begin
      pick = (held > tok_in.best) ? held : tok_in.best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (adv) begin
      tok_valid <= tok_in.valid;
    end
  end

  // Cells past the window pass the running value unchanged
  always_ff @(posedge clk) begin
    if (adv) begin
      tok_best <= in_window ? pick : tok_in.best;
    end
  end

  assign sample_out    = held;
  assign tok_out.valid = tok_valid;
  assign tok_out.best  = tok_best;

endmodule
